// ----- src/dnsa_pkg.sv -----
`default_nettype none

package dnsa_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [9:0] POS_RCODE   = 10'd3;
	localparam logic [9:0] POS_CNT_HI  = 10'd6;
	localparam logic [9:0] POS_CNT_LO  = 10'd7;
	localparam logic [9:0] POS_HDR_END = 10'd11;
	localparam logic [9:0] POS_MAX     = 10'd1023;

	localparam logic [7:0]  MAX_LABEL    = 8'd63;
	localparam logic [3:0]  TAIL_LAST    = 4'd3;
	localparam logic [3:0]  FIX_TYPE_HI  = 4'd0;
	localparam logic [3:0]  FIX_TYPE_LO  = 4'd1;
	localparam logic [3:0]  FIX_DLEN_HI  = 4'd8;
	localparam logic [3:0]  FIX_DLEN_LO  = 4'd9;
	localparam logic [15:0] RR_TYPE_A    = 16'd1;
	localparam logic [15:0] A_DATA_LEN   = 16'd4;

	typedef enum logic [2:0] {
		ST_RESOLVED  = 3'd0,
		ST_SHORT     = 3'd1,
		ST_SERVER    = 3'd2,
		ST_NO_ANS    = 3'd3,
		ST_NO_A      = 3'd4,
		ST_MALFORMED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		HP_OTHER,
		HP_RCODE,
		HP_CNT_HI,
		HP_CNT_LO,
		HP_END
	} hdr_pos_t;

	typedef enum logic [1:0] {
		NC_END,
		NC_PTR,
		NC_BAD,
		NC_LABEL
	} name_cls_t;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_Q_LEN,
		PH_Q_LABEL,
		PH_Q_PTR,
		PH_Q_TAIL,
		PH_A_LEN,
		PH_A_LABEL,
		PH_A_PTR,
		PH_A_FIXED,
		PH_A_DATA,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		hdr_pos_t   hdr_pos;
		logic       too_long;
		name_cls_t  name_cls;
	} item_t;

endpackage

`default_nettype wire

// ----- src/dnsa_in_if.sv -----
`default_nettype none

interface dnsa_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- src/dnsa_out_if.sv -----
`default_nettype none

interface dnsa_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] ipv4_addr;
	logic [3:0]  server_code;

	modport source(output valid, status, ipv4_addr, server_code, input ready);
	modport sink(input valid, status, ipv4_addr, server_code, output ready);
endinterface

`default_nettype wire

// ----- src/dnsa_front.sv -----
`default_nettype none

module dnsa_front #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	dnsa_in_if.sink      in_ch,
	input  wire logic    q_full,
	output logic         push,
	output dnsa_pkg::item_t item
);

	logic [9:0] pos_q;
	logic [7:0] b;

	assign b            = in_ch.data_byte;
	assign in_ch.ready  = !q_full;
	assign push         = in_ch.valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (in_ch.last_byte) begin
				pos_q <= '0;
			end else if (pos_q != dnsa_pkg::POS_MAX) begin
				pos_q <= pos_q + 10'd1;
			end
		end
	end

	always_comb begin
		item.data     = b;
		item.last     = in_ch.last_byte;
		item.too_long = ({1'b0, pos_q} + 11'd1) >= 11'(MAX_PACKET_BYTES);

		case (pos_q)
			dnsa_pkg::POS_RCODE:   item.hdr_pos = dnsa_pkg::HP_RCODE;
			dnsa_pkg::POS_CNT_HI:  item.hdr_pos = dnsa_pkg::HP_CNT_HI;
			dnsa_pkg::POS_CNT_LO:  item.hdr_pos = dnsa_pkg::HP_CNT_LO;
			dnsa_pkg::POS_HDR_END: item.hdr_pos = dnsa_pkg::HP_END;
			default:               item.hdr_pos = dnsa_pkg::HP_OTHER;
		endcase

		// both top bits set marks a compression pointer
		if (b == 8'd0) begin
			item.name_cls = dnsa_pkg::NC_END;
		end else if (b[7:6] == 2'b11) begin
			item.name_cls = dnsa_pkg::NC_PTR;
		end else if (b > dnsa_pkg::MAX_LABEL) begin
			item.name_cls = dnsa_pkg::NC_BAD;
		end else begin
			item.name_cls = dnsa_pkg::NC_LABEL;
		end
	end

endmodule

`default_nettype wire

// ----- src/dnsa_queue.sv -----
`default_nettype none

module dnsa_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire dnsa_pkg::item_t  push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output dnsa_pkg::item_t       head
);

	dnsa_pkg::item_t mem_q [dnsa_pkg::QDEPTH];
	logic [dnsa_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dnsa_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dnsa_pkg::QCNT_W-1:0] count_q;

	assign full       = count_q == dnsa_pkg::QCNT_W'(dnsa_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not advance on push");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue pushed while full");

endmodule

`default_nettype wire

// ----- src/dnsa_back.sv -----
`default_nettype none

module dnsa_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire dnsa_pkg::item_t head,
	output logic                 pop,
	dnsa_out_if.source           out_ch
);

	dnsa_pkg::phase_t phase_q, phase_d;
	logic [3:0]  field_cnt_q, field_cnt_d;
	logic [15:0] answers_q, answers_d;
	logic [3:0]  rcode_q, rcode_d;
	logic [5:0]  label_q, label_d;
	logic [15:0] rtype_q, rtype_d;
	logic [15:0] dlen_q, dlen_d;
	logic [31:0] acc_q, acc_d;

	logic             res_valid;
	dnsa_pkg::status_t res_status;
	logic [31:0]      res_ip;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] ip_q;
	logic [3:0]  code_q;

	logic        in_q_name;
	logic [15:0] ans_dec;
	logic [15:0] dlen_join;
	logic [31:0] acc_shift;
	logic [7:0]  b;

	assign b         = head.data;
	assign pop       = head_valid && (!out_valid_q || out_ch.ready);
	assign in_q_name = (phase_q == dnsa_pkg::PH_Q_LEN) || (phase_q == dnsa_pkg::PH_Q_LABEL) ||
	                   (phase_q == dnsa_pkg::PH_Q_PTR);
	assign ans_dec   = answers_q - 16'd1;
	assign dlen_join = dlen_q | {8'h00, b};
	assign acc_shift = {acc_q[23:0], b};

	always_comb begin
		phase_d     = phase_q;
		field_cnt_d = field_cnt_q;
		answers_d   = answers_q;
		rcode_d     = rcode_q;
		label_d     = label_q;
		rtype_d     = rtype_q;
		dlen_d      = dlen_q;
		acc_d       = acc_q;
		res_valid   = 1'b0;
		res_status  = dnsa_pkg::ST_SHORT;
		res_ip      = '0;

		case (phase_q)
			dnsa_pkg::PH_HEADER: begin
				case (head.hdr_pos)
					dnsa_pkg::HP_RCODE:  rcode_d = b[3:0];
					dnsa_pkg::HP_CNT_HI: answers_d = {b, answers_q[7:0]};
					dnsa_pkg::HP_CNT_LO: answers_d = {answers_q[15:8], b};
					dnsa_pkg::HP_END: begin
						if (rcode_q != 4'd0) begin
							res_valid  = 1'b1;
							res_status = dnsa_pkg::ST_SERVER;
						end else if (answers_q == 16'd0) begin
							res_valid  = 1'b1;
							res_status = dnsa_pkg::ST_NO_ANS;
						end else begin
							phase_d = dnsa_pkg::PH_Q_LEN;
						end
					end
					default: ;
				endcase
			end
			dnsa_pkg::PH_Q_LEN, dnsa_pkg::PH_A_LEN: begin
				case (head.name_cls)
					dnsa_pkg::NC_END: begin
						phase_d     = in_q_name ? dnsa_pkg::PH_Q_TAIL : dnsa_pkg::PH_A_FIXED;
						field_cnt_d = '0;
					end
					dnsa_pkg::NC_PTR: begin
						phase_d = in_q_name ? dnsa_pkg::PH_Q_PTR : dnsa_pkg::PH_A_PTR;
					end
					dnsa_pkg::NC_BAD: begin
						res_valid  = 1'b1;
						res_status = dnsa_pkg::ST_MALFORMED;
					end
					default: begin
						label_d = b[5:0];
						phase_d = in_q_name ? dnsa_pkg::PH_Q_LABEL : dnsa_pkg::PH_A_LABEL;
					end
				endcase
			end
			dnsa_pkg::PH_Q_LABEL, dnsa_pkg::PH_A_LABEL: begin
				label_d = label_q - 6'd1;
				if (label_q == 6'd1) begin
					phase_d = in_q_name ? dnsa_pkg::PH_Q_LEN : dnsa_pkg::PH_A_LEN;
				end
			end
			dnsa_pkg::PH_Q_PTR, dnsa_pkg::PH_A_PTR: begin
				// pointer target is never followed: the name ends here
				phase_d     = in_q_name ? dnsa_pkg::PH_Q_TAIL : dnsa_pkg::PH_A_FIXED;
				field_cnt_d = '0;
			end
			dnsa_pkg::PH_Q_TAIL: begin
				field_cnt_d = field_cnt_q + 4'd1;
				if (field_cnt_q >= dnsa_pkg::TAIL_LAST) begin
					phase_d = dnsa_pkg::PH_A_LEN;
				end
			end
			dnsa_pkg::PH_A_FIXED: begin
				field_cnt_d = field_cnt_q + 4'd1;
				if (field_cnt_q == dnsa_pkg::FIX_TYPE_HI) begin
					rtype_d = {b, 8'h00};
				end else if (field_cnt_q == dnsa_pkg::FIX_TYPE_LO) begin
					rtype_d = rtype_q | {8'h00, b};
				end else if (field_cnt_q == dnsa_pkg::FIX_DLEN_HI) begin
					dlen_d = {b, 8'h00};
				end else if (field_cnt_q >= dnsa_pkg::FIX_DLEN_LO) begin
					dlen_d = dlen_join;
					acc_d  = '0;
					// keep the type only for an A record of the right length
					if (!(rtype_q == dnsa_pkg::RR_TYPE_A && dlen_join == dnsa_pkg::A_DATA_LEN)) begin
						rtype_d = '0;
					end
					if (dlen_join == 16'd0) begin
						answers_d = ans_dec;
						if (ans_dec == 16'd0) begin
							res_valid  = 1'b1;
							res_status = dnsa_pkg::ST_NO_A;
						end else begin
							phase_d = dnsa_pkg::PH_A_LEN;
						end
					end else begin
						phase_d = dnsa_pkg::PH_A_DATA;
					end
				end
			end
			dnsa_pkg::PH_A_DATA: begin
				if (rtype_q == dnsa_pkg::RR_TYPE_A) begin
					acc_d = acc_shift;
				end
				dlen_d = dlen_q - 16'd1;
				if (dlen_q == 16'd1) begin
					if (rtype_q == dnsa_pkg::RR_TYPE_A) begin
						res_valid  = 1'b1;
						res_status = dnsa_pkg::ST_RESOLVED;
						res_ip     = acc_shift;
					end else begin
						answers_d = ans_dec;
						if (ans_dec == 16'd0) begin
							res_valid  = 1'b1;
							res_status = dnsa_pkg::ST_NO_A;
						end else begin
							phase_d = dnsa_pkg::PH_A_LEN;
						end
					end
				end
			end
			default: ;
		endcase

		if (res_valid) begin
			phase_d = dnsa_pkg::PH_DONE;
		end else if (phase_q != dnsa_pkg::PH_DONE && (head.last || head.too_long)) begin
			res_valid  = 1'b1;
			res_status = dnsa_pkg::ST_SHORT;
			phase_d    = dnsa_pkg::PH_DONE;
		end

		// end of packet: back to the reset state for the next one
		if (head.last) begin
			phase_d     = dnsa_pkg::PH_HEADER;
			field_cnt_d = '0;
			answers_d   = '0;
			label_d     = '0;
			rtype_d     = '0;
			dlen_d      = '0;
			acc_d       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dnsa_pkg::PH_HEADER;
			field_cnt_q <= '0;
			answers_q   <= '0;
			rcode_q     <= '0;
			label_q     <= '0;
			rtype_q     <= '0;
			dlen_q      <= '0;
			acc_q       <= '0;
		end else if (pop) begin
			phase_q     <= phase_d;
			field_cnt_q <= field_cnt_d;
			answers_q   <= answers_d;
			rcode_q     <= head.last ? 4'd0 : rcode_d;
			label_q     <= label_d;
			rtype_q     <= rtype_d;
			dlen_q      <= dlen_d;
			acc_q       <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			status_q <= res_status;
			ip_q     <= res_ip;
			code_q   <= rcode_d;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.ipv4_addr   = ip_q;
	assign out_ch.server_code = code_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && phase_q == dnsa_pkg::PH_DONE |-> !res_valid)
		else $error("second result for one packet");

	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_valid && !head.last |=> phase_q == dnsa_pkg::PH_DONE)
		else $error("parser did not hold after its result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status) &&
			$stable(out_ch.ipv4_addr))
		else $error("result changed while stalled");

endmodule

`default_nettype wire

// ----- src/dns_a_record_response_parser.sv -----
// A byte accepted at the input is first written into the queue; once the parser pops it,
// the result that it decides, if any, is held in the parser's output register.
// Throughput: one byte per cycle while the output is not stalled, one parser phase update per byte.
// A stalled output holds the parser while the queue takes up to four more bytes.
// Reset (arst_n low, asynchronous): queue empty, parser in the header phase, no result.
// Each packet ends at last_byte; all parse state then returns to its reset value.
`default_nettype none

module dns_a_record_response_parser #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input wire logic   clk,
	input wire logic   arst_n,
	dnsa_in_if.sink    in_ch,
	dnsa_out_if.source out_ch
);

	logic            push;
	logic            q_full;
	logic            pop;
	logic            head_valid;
	dnsa_pkg::item_t push_item;
	dnsa_pkg::item_t head;

	dnsa_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.q_full(q_full),
		.push  (push),
		.item  (push_item)
	);

	dnsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	dnsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

// ----- dv/dns_a_record_response_parser_tb.sv -----
`default_nettype none

module dns_a_record_response_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PKT = 512;

	typedef struct {
		dnsa_pkg::status_t status;
		logic [31:0]       ip;
		logic [3:0]        code;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dnsa_in_if  in_ch();
	dnsa_out_if out_ch();

	dns_a_record_response_parser #(
		.MAX_PACKET_BYTES(MAX_PKT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// parser state as the block should hold it
	dnsa_pkg::phase_t ph;
	logic [9:0]  byte_pos;
	logic [3:0]  fcnt;
	logic [15:0] ans_left;
	logic [3:0]  rcode;
	logic [5:0]  lab_left;
	logic [15:0] rtype;
	logic [15:0] rdlen;
	logic [31:0] addr;
	logic        decided;

	lookup_t    pending_lookups[$];
	logic [7:0] pkt[$];
	bit         gaps_on;
	int         errors;
	int         live_bytes;
	int         bytes_sent;
	int         results_seen;
	int         packets_sent;
	int         status_seen[8];

	function automatic void clear_parse();
		ph = dnsa_pkg::PH_HEADER;
		byte_pos = '0;
		fcnt = '0;
		ans_left = '0;
		rcode = '0;
		lab_left = '0;
		rtype = '0;
		rdlen = '0;
		addr = '0;
		decided = 1'b0;
	endfunction

	// One byte of a name; returns 1 on a label length that is neither a label nor a pointer
	function automatic bit name_step(dnsa_pkg::phase_t base, logic [7:0] b);
		int sub;
		sub = int'(ph) - int'(base);
		if (sub == 0) begin
			if (b == 8'h00) begin
				ph = dnsa_pkg::phase_t'(int'(base) + 3);
				fcnt = '0;
			end else if (b[7:6] == 2'b11) begin
				ph = dnsa_pkg::phase_t'(int'(base) + 2);
			end else if (b > dnsa_pkg::MAX_LABEL) begin
				return 1'b1;
			end else begin
				lab_left = b[5:0];
				ph = dnsa_pkg::phase_t'(int'(base) + 1);
			end
		end else if (sub == 1) begin
			lab_left = lab_left - 6'd1;
			if (lab_left == '0)
				ph = base;
		end else begin
			// second pointer byte: the target is never followed
			ph = dnsa_pkg::phase_t'(int'(base) + 3);
			fcnt = '0;
		end
		return 1'b0;
	endfunction

	function automatic bit retire_answer();
		ans_left = ans_left - 16'd1;
		if (ans_left == '0)
			return 1'b1;
		ph = dnsa_pkg::PH_A_LEN;
		return 1'b0;
	endfunction

	task automatic parse_dns_byte(input logic [7:0] b, input logic last);
		logic [9:0]        pos;
		bit                hit;
		dnsa_pkg::status_t st;
		logic [31:0]       ip;
		lookup_t           res;
		pos = byte_pos;
		hit = 1'b0;
		st = dnsa_pkg::ST_SHORT;
		ip = '0;
		bytes_sent++;
		if (!decided)
			live_bytes++;
		case (ph)
			dnsa_pkg::PH_HEADER: begin
				if (pos == dnsa_pkg::POS_RCODE) begin
					rcode = b[3:0];
				end else if (pos == dnsa_pkg::POS_CNT_HI) begin
					ans_left[15:8] = b;
				end else if (pos == dnsa_pkg::POS_CNT_LO) begin
					ans_left[7:0] = b;
				end else if (pos == dnsa_pkg::POS_HDR_END) begin
					// a server error wins over an empty answer section
					if (rcode != '0) begin
						hit = 1'b1;
						st = dnsa_pkg::ST_SERVER;
					end else if (ans_left == '0) begin
						hit = 1'b1;
						st = dnsa_pkg::ST_NO_ANS;
					end else begin
						ph = dnsa_pkg::PH_Q_LEN;
					end
				end
			end
			dnsa_pkg::PH_Q_LEN, dnsa_pkg::PH_Q_LABEL, dnsa_pkg::PH_Q_PTR: begin
				if (name_step(dnsa_pkg::PH_Q_LEN, b)) begin
					hit = 1'b1;
					st = dnsa_pkg::ST_MALFORMED;
				end
			end
			dnsa_pkg::PH_Q_TAIL: begin
				fcnt = fcnt + 4'd1;
				if (fcnt >= 4'd4)
					ph = dnsa_pkg::PH_A_LEN;
			end
			dnsa_pkg::PH_A_LEN, dnsa_pkg::PH_A_LABEL, dnsa_pkg::PH_A_PTR: begin
				if (name_step(dnsa_pkg::PH_A_LEN, b)) begin
					hit = 1'b1;
					st = dnsa_pkg::ST_MALFORMED;
				end
			end
			dnsa_pkg::PH_A_FIXED: begin
				if (fcnt == dnsa_pkg::FIX_TYPE_HI) begin
					rtype = {b, 8'h00};
				end else if (fcnt == dnsa_pkg::FIX_TYPE_LO) begin
					rtype = rtype | {8'h00, b};
				end else if (fcnt == dnsa_pkg::FIX_DLEN_HI) begin
					rdlen = {b, 8'h00};
				end else if (fcnt >= dnsa_pkg::FIX_DLEN_LO) begin
					rdlen = rdlen | {8'h00, b};
					if (!(rtype == dnsa_pkg::RR_TYPE_A && rdlen == dnsa_pkg::A_DATA_LEN))
						rtype = '0;
					addr = '0;
					if (rdlen == '0) begin
						if (retire_answer()) begin
							hit = 1'b1;
							st = dnsa_pkg::ST_NO_A;
						end
					end else begin
						ph = dnsa_pkg::PH_A_DATA;
					end
				end
				fcnt = fcnt + 4'd1;
			end
			dnsa_pkg::PH_A_DATA: begin
				if (rtype == dnsa_pkg::RR_TYPE_A)
					addr = {addr[23:0], b};
				rdlen = rdlen - 16'd1;
				if (rdlen == '0) begin
					if (rtype == dnsa_pkg::RR_TYPE_A) begin
						hit = 1'b1;
						st = dnsa_pkg::ST_RESOLVED;
						ip = addr;
					end else if (retire_answer()) begin
						hit = 1'b1;
						st = dnsa_pkg::ST_NO_A;
					end
				end
			end
			default: ;
		endcase
		if (hit) begin
			decided = 1'b1;
			ph = dnsa_pkg::PH_DONE;
		end else if (!decided && (last || int'(pos) + 1 >= MAX_PKT)) begin
			hit = 1'b1;
			st = dnsa_pkg::ST_SHORT;
			decided = 1'b1;
			ph = dnsa_pkg::PH_DONE;
		end
		if (hit) begin
			res.status = st;
			res.ip = ip;
			res.code = rcode;
			pending_lookups.push_back(res);
		end
		if (byte_pos < dnsa_pkg::POS_MAX)
			byte_pos = byte_pos + 10'd1;
		if (last)
			clear_parse();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				status_seen[out_ch.status]++;
				if (pending_lookups.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d ip %h code %h",
						$time, out_ch.status, out_ch.ipv4_addr, out_ch.server_code);
					errors++;
				end else begin
					lookup_t exp_l;
					exp_l = pending_lookups.pop_front();
					if (out_ch.status !== exp_l.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_l.status, out_ch.status);
						errors++;
					end
					if (out_ch.ipv4_addr !== exp_l.ip) begin
						$display("%0t: ipv4_addr expected %h actual %h",
							$time, exp_l.ip, out_ch.ipv4_addr);
						errors++;
					end
					if (out_ch.server_code !== exp_l.code) begin
						$display("%0t: server_code expected %h actual %h",
							$time, exp_l.code, out_ch.server_code);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				parse_dns_byte(in_ch.data_byte, in_ch.last_byte);
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= !(gaps_on && $urandom_range(99) < 7);
	end

	task automatic send_byte(input logic [7:0] d, input logic l);
		while (gaps_on && $urandom_range(99) < 7) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= d;
		in_ch.last_byte <= l;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_packet();
		int i;
		for (i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		pkt.delete();
		packets_sent++;
	endtask

	// Drop valid and hold until every lookup in flight has come back
	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_header(input logic [3:0] code, input logic [15:0] ancount);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back({4'($urandom), code});
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(ancount[15:8]);
		pkt.push_back(ancount[7:0]);
		repeat (4) pkt.push_back(8'($urandom));
	endtask

	task automatic put_name(input int labels, input int lo, input int hi, input bit ptr);
		int n;
		repeat (labels) begin
			n = $urandom_range(hi, lo);
			pkt.push_back(8'(n));
			repeat (n) pkt.push_back(8'($urandom));
		end
		if (ptr) begin
			pkt.push_back({2'b11, 6'($urandom)});
			pkt.push_back(8'($urandom));
		end else begin
			pkt.push_back(8'h00);
		end
	endtask

	task automatic put_question(input int labels, input int lo, input int hi, input bit ptr);
		put_name(labels, lo, hi, ptr);
		repeat (4) pkt.push_back(8'($urandom));
	endtask

	task automatic put_answer(input logic [15:0] typ, input logic [15:0] len,
			input logic [31:0] ip);
		int n;
		int i;
		n = ($urandom_range(3) == 0) ? $urandom_range(2) : 0;
		put_name(n, 1, 6, n == 0 || $urandom_range(1) == 1);
		pkt.push_back(typ[15:8]);
		pkt.push_back(typ[7:0]);
		// class and TTL
		repeat (6) pkt.push_back(8'($urandom));
		pkt.push_back(len[15:8]);
		pkt.push_back(len[7:0]);
		for (i = 0; i < int'(len); i++)
			pkt.push_back(i < 4 ? ip[31 - 8 * i -: 8] : 8'($urandom));
	endtask

	task automatic test_header_outcomes();
		put_header(4'hF, 16'h0000);
		send_packet();
		put_header(4'h0, 16'h0000);
		send_packet();
		// decided at the header; the question and answer that follow are ignored
		put_header(4'h1, 16'd3);
		put_question(2, 1, 5, 0);
		put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, 32'hC0A80001);
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_resolved();
		put_header(4'h0, 16'd1);
		put_question(1, 3, 3, 0);
		put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, 32'h00000000);
		send_packet();
		put_header(4'h0, 16'hFFFF);
		put_question(0, 1, 1, 0);
		put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, 32'hFFFFFFFF);
		send_packet();
		put_header(4'h0, 16'd1);
		put_question(1, 63, 63, 1);
		put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, $urandom);
		repeat (3) pkt.push_back(8'($urandom));
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_skipped_answers();
		put_header(4'h0, 16'd3);
		put_question(2, 1, 8, 0);
		put_answer(16'd5, 16'd6, $urandom);
		put_answer(dnsa_pkg::RR_TYPE_A, 16'd0, $urandom);
		put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, $urandom);
		send_packet();
		put_header(4'h0, 16'd2);
		put_question(1, 1, 8, 1);
		put_answer(16'd28, 16'd16, $urandom);
		put_answer(16'h0101, dnsa_pkg::A_DATA_LEN, $urandom);
		send_packet();
		put_header(4'h0, 16'd2);
		put_question(1, 1, 8, 0);
		put_answer(dnsa_pkg::RR_TYPE_A, 16'd5, $urandom);
		// data length with a nonzero high byte; the packet ends inside the data
		put_answer(16'hFFFF, 16'h0100, $urandom);
		repeat (250) void'(pkt.pop_back());
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_malformed_names();
		put_header(4'h0, 16'd1);
		pkt.push_back(8'd64);
		repeat (6) pkt.push_back(8'($urandom));
		send_packet();
		put_header(4'h0, 16'd1);
		put_question(1, 4, 4, 0);
		pkt.push_back(8'd2);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		pkt.push_back(8'd191);
		send_packet();
		// 0xC0 is the smallest pointer, not a bad label
		put_header(4'h0, 16'd1);
		put_question(0, 1, 1, 0);
		pkt.push_back(8'hC0);
		pkt.push_back(8'h0C);
		repeat (6) pkt.push_back(8'($urandom));
		pkt.push_back(8'h00);
		pkt.push_back(8'h04);
		repeat (4) pkt.push_back(8'($urandom));
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_short_packets();
		pkt.push_back(8'($urandom));
		send_packet();
		put_header(4'h9, 16'd1);
		while (pkt.size() > 4)
			void'(pkt.pop_back());
		send_packet();
		put_header(4'h0, 16'd1);
		send_packet();
		// last byte of the header decides and ends the packet together
		put_header(4'h3, 16'd0);
		send_packet();
		put_header(4'h0, 16'd2);
		put_question(1, 2, 6, 0);
		put_answer(16'd5, dnsa_pkg::A_DATA_LEN, $urandom);
		send_packet();
		put_header(4'h0, 16'd1);
		put_question(1, 2, 6, 0);
		put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, $urandom);
		void'(pkt.pop_back());
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_long_packets();
		// labels of 63 run past the size limit with no decision
		put_header(4'h0, 16'd1);
		put_name(8, 63, 63, 0);
		send_packet();
		put_header(4'h0, 16'd1);
		put_question(1, 3, 3, 0);
		put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, $urandom);
		send_packet();
		hold_until_drained();
	endtask

	task automatic test_random_responses();
		int base_bytes;
		int r;
		int i;
		int nans;
		int bad_at;
		logic [3:0]  code;
		logic [15:0] anc;
		base_bytes = bytes_sent;
		gaps_on = 1'b0;
		while (bytes_sent - base_bytes < 320) begin
			gaps_on = (bytes_sent - base_bytes) >= 120;
			r = $urandom_range(99);
			if (r < 5) begin
				repeat ($urandom_range(40, 1)) pkt.push_back(8'($urandom));
			end else begin
				code = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 1)) : 4'd0;
				nans = $urandom_range(4, 1);
				r = $urandom_range(99);
				if (r < 6)
					anc = 16'd0;
				else if (r < 14)
					anc = 16'(nans + $urandom_range(3, 1));
				else if (r < 18)
					anc = 16'($urandom);
				else
					anc = 16'(nans);
				bad_at = ($urandom_range(99) < 8) ? $urandom_range(nans) : -1;
				put_header(code, anc);
				if (bad_at == 0)
					pkt.push_back(8'($urandom_range(191, 64)));
				put_question($urandom_range(3), 1,
					($urandom_range(9) == 0) ? 63 : 10, $urandom_range(4) == 0);
				for (i = 1; i <= nans; i++) begin
					if (bad_at == i)
						pkt.push_back(8'($urandom_range(191, 64)));
					r = $urandom_range(99);
					if (r < 50)
						put_answer(dnsa_pkg::RR_TYPE_A, dnsa_pkg::A_DATA_LEN, $urandom);
					else if (r < 70)
						put_answer(16'($urandom_range(255)), 16'($urandom_range(20)), $urandom);
					else if (r < 82)
						put_answer(dnsa_pkg::RR_TYPE_A, 16'($urandom_range(8)), $urandom);
					else
						put_answer(16'($urandom), dnsa_pkg::A_DATA_LEN, $urandom);
				end
				if ($urandom_range(99) < 8) begin
					r = $urandom_range(pkt.size(), 1);
					while (pkt.size() > r)
						void'(pkt.pop_back());
				end
				if ($urandom_range(99) < 15)
					repeat ($urandom_range(8, 1)) pkt.push_back(8'($urandom));
			end
			send_packet();
			if ($urandom_range(19) == 0)
				hold_until_drained();
		end
		hold_until_drained();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		gaps_on = 1'b1;
		clear_parse();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_outcomes();
		test_resolved();
		test_skipped_answers();
		test_malformed_names();
		test_short_packets();
		test_long_packets();
		test_random_responses();

		repeat (10) @(posedge clk);
		$display("%0d packets, %0d bytes (%0d before a decision), %0d results checked",
			packets_sent, bytes_sent, live_bytes, results_seen);
		$display("by status: resolved %0d short %0d server %0d no-answer %0d no-A %0d",
			status_seen[dnsa_pkg::ST_RESOLVED], status_seen[dnsa_pkg::ST_SHORT],
			status_seen[dnsa_pkg::ST_SERVER], status_seen[dnsa_pkg::ST_NO_ANS],
			status_seen[dnsa_pkg::ST_NO_A]);
		$display("bad-name %0d", status_seen[dnsa_pkg::ST_MALFORMED]);
		if (errors == 0 && pending_lookups.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("%0t: run did not finish, %0d lookups outstanding", $time,
			pending_lookups.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
src/dnsa_pkg.sv
src/dnsa_in_if.sv
src/dnsa_out_if.sv
src/dnsa_front.sv
src/dnsa_queue.sv
src/dnsa_back.sv
src/dns_a_record_response_parser.sv
dv/dns_a_record_response_parser_tb.sv
